// File: rtl/core/waveform_peak_binning_macros.svh
// Assertion macros shared by the waveform peak binning RTL.
`ifndef WAVEFORM_PEAK_BINNING_MACROS_SVH
`define WAVEFORM_PEAK_BINNING_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define WPB_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("waveform peak binning assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define WPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("waveform peak binning assertion failed");
`else
`define WPB_ASSERT(label, clk, rst_n, ante, cons)
`define WPB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/wpb_pkg.sv
// Shared types, widths and register codes of the waveform peak binning block.
package wpb_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int MAG_W      = 31;
  localparam int BIN_W      = 16;
  localparam int BINCNT_W   = 17;
  localparam int CH_W       = 6;
  localparam int FRAME_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT     = 2'd2;

  localparam logic [MAG_W-1:0] INF_MAG = 31'h7F80_0000;

  localparam int DEF_MAX_CHANNELS = 32;
  localparam int DEF_MAX_BINS     = 65536;

  // Effective configuration as seen by the datapath.
  typedef struct packed {
    logic [CH_W-1:0]    ch_last;      // channels per frame minus one
    logic [FRAME_W-1:0] total_frames;
    logic [BIN_W-1:0]   bins_m1;      // bins minus one
    logic               restart;      // a known register is being written
  } cfg_t;

endpackage

// File: rtl/core/wpb_if.sv
// Request channel interfaces of the waveform peak binning block.
interface wpb_in_if;
  logic                           valid;
  logic                           ready;
  logic [wpb_pkg::SAMPLE_W-1:0]   sample_bits;
  modport source (output valid, output sample_bits, input ready);
  modport sink   (input valid, input sample_bits, output ready);
endinterface

interface wpb_out_if;
  logic                           valid;
  logic                           ready;
  logic [wpb_pkg::BIN_W-1:0]      bin_index;
  logic [wpb_pkg::MAG_W-1:0]      peak_magnitude;
  logic                           last_bin;
  modport source (output valid, output bin_index, output peak_magnitude,
                  output last_bin, input ready);
  modport sink   (input valid, input bin_index, input peak_magnitude,
                  input last_bin, output ready);
endinterface

interface wpb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wpb_pkg::CFG_IDX_W-1:0]  index;
  logic [wpb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/wpb_cfg.sv
// Configuration registers with clamping of channel and bin counts.
module wpb_cfg #(
  parameter int MAX_CHANNELS = wpb_pkg::DEF_MAX_CHANNELS
) (
  input  logic           clk,
  input  logic           rst_n,
  wpb_cfg_if.sink        cfg_chan,
  output wpb_pkg::cfg_t  cfg_o
);

  logic [wpb_pkg::CH_W-1:0]     ch_last_r, ch_last_nxt;
  logic [wpb_pkg::FRAME_W-1:0]  total_r, total_nxt;
  logic [wpb_pkg::BIN_W-1:0]    bins_m1_r, bins_m1_nxt;
  logic [wpb_pkg::CH_W-1:0]     cc;
  logic [wpb_pkg::BINCNT_W-1:0] bc;
  logic                         wr;
  logic                         known;

  assign cfg_chan.ready = 1'b1;
  assign wr = cfg_chan.valid;
  assign cc = cfg_chan.data[wpb_pkg::CH_W-1:0];
  assign bc = cfg_chan.data[wpb_pkg::BINCNT_W-1:0];

  always_comb begin
    ch_last_nxt = ch_last_r;
    total_nxt   = total_r;
    bins_m1_nxt = bins_m1_r;
    known       = 1'b0;
    if (wr) begin
      unique case (cfg_chan.index)
        wpb_pkg::CFG_CHANNEL_COUNT: begin
          known = 1'b1;
          if (cc == '0) begin
            ch_last_nxt = '0;
          end else if (32'(cc) > 32'(MAX_CHANNELS)) begin
            ch_last_nxt = wpb_pkg::CH_W'(MAX_CHANNELS - 1);
          end else begin
            ch_last_nxt = cc - 1'b1;
          end
        end
        wpb_pkg::CFG_TOTAL_FRAMES: begin
          known     = 1'b1;
          total_nxt = cfg_chan.data[wpb_pkg::FRAME_W-1:0];
        end
        wpb_pkg::CFG_BIN_COUNT: begin
          known = 1'b1;
          if (bc == '0) begin
            bins_m1_nxt = '0;
          end else if (32'(bc) > 32'(wpb_pkg::DEF_MAX_BINS)) begin
            bins_m1_nxt = wpb_pkg::BIN_W'(wpb_pkg::DEF_MAX_BINS - 1);
          end else begin
            bins_m1_nxt = wpb_pkg::BIN_W'(bc - 1'b1);
          end
        end
        default: known = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_last_r <= '0;
      total_r   <= '0;
      bins_m1_r <= '0;
    end else begin
      ch_last_r <= ch_last_nxt;
      total_r   <= total_nxt;
      bins_m1_r <= bins_m1_nxt;
    end
  end

  always_comb begin
    cfg_o.ch_last      = ch_last_r;
    cfg_o.total_frames = total_r;
    cfg_o.bins_m1      = bins_m1_r;
    cfg_o.restart      = known;
  end

endmodule

// File: rtl/core/waveform_peak_binning.sv
// Top level of the waveform peak binning block: running peaks, counters, result register.
// A request that closes a bin shows its result in the cycle after it is accepted, unless
// a configuration write lands in that cycle. Throughput: one sample request per cycle; a
// request that closes a bin waits only while the result register is full and not taken.
// Reset: synchronous, active low; restores one channel, zero frames and one bin and clears
// all counters and peaks. A write to a known configuration register restarts the stream.
`include "waveform_peak_binning_macros.svh"

module waveform_peak_binning #(
  parameter int MAX_CHANNELS = wpb_pkg::DEF_MAX_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  wpb_in_if.sink     in_chan,
  wpb_out_if.source  out_chan,
  wpb_cfg_if.sink    cfg_chan
);

  wpb_pkg::cfg_t cfg;

  // The configuration block clamps the counts and flags a stream restart on every write
  // to a register that exists; writes to other indexes are accepted and dropped. The bin
  // limit is fixed by the package, since it also sets the width of the bin counter.
  wpb_cfg #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  // Stream state.
  logic [wpb_pkg::CH_W-1:0]    ch_pos_r, ch_pos_nxt;
  logic [wpb_pkg::FRAME_W-1:0] frame_pos_r, frame_pos_nxt;
  logic [wpb_pkg::BIN_W-1:0]   cur_bin_r, cur_bin_nxt;
  logic [wpb_pkg::FRAME_W-1:0] acc_r, acc_nxt;
  logic [wpb_pkg::MAG_W-1:0]   frame_peak_r, frame_peak_nxt;
  logic [wpb_pkg::MAG_W-1:0]   bin_peak_r, bin_peak_nxt;

  // Result register.
  logic                        out_valid_r, out_valid_nxt;
  logic [wpb_pkg::BIN_W-1:0]   out_bin_r, out_bin_nxt;
  logic [wpb_pkg::MAG_W-1:0]   out_peak_r, out_peak_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                          in_fire;
  logic                          done;
  logic                          frame_end;
  logic                          last;
  logic                          hit;
  logic                          close_now;
  logic                          out_free;
  logic [wpb_pkg::MAG_W-1:0]     mag;
  logic [wpb_pkg::MAG_W-1:0]     fpeak_upd;
  logic [wpb_pkg::MAG_W-1:0]     bpeak_upd;
  logic [wpb_pkg::FRAME_W-1:0]   frame_pos_inc;
  logic [wpb_pkg::BINCNT_W-1:0]  eff_bins;
  logic [wpb_pkg::FRAME_W:0]     acc_sum;

  // Once every frame of the recording has been seen, further samples are
  // taken and thrown away.
  assign done = frame_pos_r >= cfg.total_frames;

  // The magnitude is the word with its sign cleared. Words above infinity are NaN
  // and never raise the peak.
  assign mag       = in_chan.sample_bits[wpb_pkg::MAG_W-1:0];
  assign fpeak_upd = (mag <= wpb_pkg::INF_MAG && mag > frame_peak_r) ? mag : frame_peak_r;
  assign bpeak_upd = (fpeak_upd > bin_peak_r) ? fpeak_upd : bin_peak_r;

  assign frame_end     = ch_pos_r == cfg.ch_last;
  assign frame_pos_inc = frame_pos_r + 1'b1;
  assign last          = frame_pos_inc == cfg.total_frames;

  // Rather than dividing for the bin length, acc_r holds frames_in_bin times the bin
  // count, clamped at the frame total. A bin is full exactly when that product reaches
  // the total, which is the same test as frames_in_bin >= ceil(total / bins).
  assign eff_bins = {1'b0, cfg.bins_m1} + 1'b1;
  assign acc_sum  = {1'b0, acc_r} + (wpb_pkg::FRAME_W + 1)'(eff_bins);
  assign hit      = acc_sum >= {1'b0, cfg.total_frames};

  // Whether the next sample closes a bin depends on the state alone, so the ready
  // signal needs nothing from the sample itself. The final bin only closes on the
  // last frame.
  assign close_now = !done && frame_end && (last || (hit && cur_bin_r != cfg.bins_m1));

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = out_free || !close_now;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    ch_pos_nxt     = ch_pos_r;
    frame_pos_nxt  = frame_pos_r;
    cur_bin_nxt    = cur_bin_r;
    acc_nxt        = acc_r;
    frame_peak_nxt = frame_peak_r;
    bin_peak_nxt   = bin_peak_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_bin_nxt    = out_bin_r;
    out_peak_nxt   = out_peak_r;
    out_last_nxt   = out_last_r;

    if (cfg.restart) begin
      // A configuration write starts the stream afresh.
      ch_pos_nxt     = '0;
      frame_pos_nxt  = '0;
      cur_bin_nxt    = '0;
      acc_nxt        = '0;
      frame_peak_nxt = '0;
      bin_peak_nxt   = '0;
      out_valid_nxt  = 1'b0;
    end else if (in_fire && !done) begin
      if (!frame_end) begin
        ch_pos_nxt     = ch_pos_r + 1'b1;
        frame_peak_nxt = fpeak_upd;
      end else begin
        ch_pos_nxt     = '0;
        frame_peak_nxt = '0;
        frame_pos_nxt  = frame_pos_inc;
        if (close_now) begin
          out_valid_nxt = 1'b1;
          out_bin_nxt   = cur_bin_r;
          out_peak_nxt  = bpeak_upd;
          out_last_nxt  = last;
          bin_peak_nxt  = '0;
          acc_nxt       = '0;
          if (!last) begin
            cur_bin_nxt = cur_bin_r + 1'b1;
          end
        end else begin
          bin_peak_nxt = bpeak_upd;
          // When not hit the sum is below the total, so it fits the frame width.
          acc_nxt      = hit ? cfg.total_frames : acc_sum[wpb_pkg::FRAME_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_pos_r     <= '0;
      frame_pos_r  <= '0;
      cur_bin_r    <= '0;
      acc_r        <= '0;
      frame_peak_r <= '0;
      bin_peak_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      ch_pos_r     <= ch_pos_nxt;
      frame_pos_r  <= frame_pos_nxt;
      cur_bin_r    <= cur_bin_nxt;
      acc_r        <= acc_nxt;
      frame_peak_r <= frame_peak_nxt;
      bin_peak_r   <= bin_peak_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload of the result register carries no reset.
  always_ff @(posedge clk) begin
    out_bin_r  <= out_bin_nxt;
    out_peak_r <= out_peak_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.bin_index      = out_bin_r;
  assign out_chan.peak_magnitude = out_peak_r;
  assign out_chan.last_bin       = out_last_r;

  `WPB_ASSERT(a_peak_not_nan, clk, rst_n, out_valid_r, out_peak_r <= wpb_pkg::INF_MAG)
  `WPB_ASSERT(a_ch_pos_bound, clk, rst_n, 1'b1, ch_pos_r <= cfg.ch_last)
  `WPB_ASSERT(a_bin_bound, clk, rst_n, 1'b1, cur_bin_r <= cfg.bins_m1)
  `WPB_ASSERT_NEXT(a_restart_clears, clk, rst_n, cfg.restart, frame_pos_r == '0 && !out_valid_r)

endmodule
